### hw/rtl/dnsm_pkg.sv
// Shared types, constants and tone table for the disk noise synthesiser and mixer.
`default_nettype none
package dnsm_pkg;

	localparam int KINDS = 6;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] PENDING_LIMIT = 4'd8;

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam int CFG_W = 18;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO   = 2'd2;

	localparam logic [6:0]  VOLUME_RESET = 7'd35;
	localparam logic [17:0] RATE_RESET   = 18'd44100;
	localparam logic [6:0]  PCT_MAX      = 7'd100;

	// floor(x / 100) = (x * VOL_RECIP) >> VOL_SHIFT for x below 2^17
	localparam logic [17:0] VOL_RECIP = 18'd167773;
	localparam int VOL_SHIFT = 24;

	localparam int DIV_N = 42;
	localparam int DIV_D = 27;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic              op;
		logic [2:0]        event_kind;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} out_item_t;

	typedef struct packed {
		logic [11:0] length;
		logic [9:0]  freq;
		logic [9:0]  vol;
	} tone_spec_t;

	typedef struct packed {
		logic ev_take;
		logic frame_take;
		logic pick;
		logic vol_mul;
		logic vol_rec;
		logic vol_set;
		logic div1_go;
		logic phase_upd;
		logic amp_mul1;
		logic amp_mul2;
		logic div2_go;
		logic tone_upd;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rate_zero;
		logic tone_busy;
		logic pend_any;
		logic div_done;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PICK,
		ST_VMUL,
		ST_VREC,
		ST_VSET,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_OUT
	} state_t;

	function automatic tone_spec_t tone_lookup(input logic [2:0] k);
		tone_spec_t s;
		case (k)
			3'd0: s = '{length: 12'd1058, freq: 10'd820, vol: 10'd950};
			3'd1: s = '{length: 12'd2880, freq: 10'd125, vol: 10'd500};
			3'd2: s = '{length: 12'd720,  freq: 10'd420, vol: 10'd300};
			3'd3: s = '{length: 12'd720,  freq: 10'd310, vol: 10'd340};
			3'd4: s = '{length: 12'd480,  freq: 10'd210, vol: 10'd260};
			3'd5: s = '{length: 12'd480,  freq: 10'd165, vol: 10'd280};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/dnsm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module dnsm_div
	import dnsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DIV_N-1:0] dividend,
	input  wire logic [DIV_D-1:0] divisor,
	output logic                  done,
	output logic [DIV_N-1:0]      quotient
);

	logic [DIV_D-1:0]     rem_q;
	logic [DIV_N-1:0]     quo_q;
	logic [DIV_D-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_D:0]   trial;
	logic [DIV_D:0]   diff;
	logic             ge;
	logic [DIV_D-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, quo_q[DIV_N-1]};
		diff   = trial - {1'b0, dvs_q};
		ge     = trial >= {1'b0, dvs_q};
		rem_nx = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### hw/rtl/dnsm_datapath.sv
// Datapath: configuration, pending counters, tone state, envelope arithmetic and output register.
`default_nettype none
module dnsm_datapath
	import dnsm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	input  wire in_item_t             in_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output dp_stat_t                  stat,
	output out_item_t                 out_data
);

	logic [6:0]       vol_pct_q;
	logic [17:0]      rate_q;
	logic             mono_q;

	logic [CNT_W-1:0] pend_q [KINDS];
	logic [2:0]       tone_kind_q;
	logic [11:0]      tone_left_q;
	logic [11:0]      tone_length_q;
	logic [9:0]       tone_freq_q;
	logic [9:0]       tone_vol_q;
	logic [31:0]      tone_phase_q;
	logic             mix_q;

	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic [16:0]        vprod_q;
	logic [34:0]        vrec_q;
	logic [24:0]        m1_q;
	logic               neg_q;
	logic [36:0]        m2_q;
	logic signed [10:0] value_q;
	out_item_t          out_q;

	logic             pick_hit;
	logic [2:0]       pick_k;
	tone_spec_t       spec;
	logic [6:0]       pct_c;
	logic [15:0]      tri_t;
	logic [15:0]      tri_w;
	logic [14:0]      tri_mag;
	logic             tri_neg;
	logic [DIV_D-1:0] den;
	logic             div_go;
	logic [DIV_N-1:0] div_dividend;
	logic [DIV_D-1:0] div_divisor;
	logic             div_done;
	logic [DIV_N-1:0] div_quo;
	logic [10:0]      quo_ext;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767)
			return 16'sh7fff;
		else if (v < -17'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	always_comb begin
		pick_hit = 1'b0;
		pick_k   = '0;
		for (int k = KINDS - 1; k >= 0; k--) begin
			if (pend_q[k] != '0) begin
				pick_hit = 1'b1;
				pick_k   = 3'(k);
			end
		end
	end

	always_comb begin
		spec    = tone_lookup(pick_k);
		pct_c   = (vol_pct_q > PCT_MAX) ? PCT_MAX : vol_pct_q;
		tri_t   = tone_phase_q[31:16];
		tri_w   = {(tri_t[15] ? ~tri_t[14:0] : tri_t[14:0]), 1'b0};
		tri_neg = tri_w < 16'd32767;
		tri_mag = tri_neg ? 15'(16'd32767 - tri_w) : 15'(tri_w - 16'd32767);
		den     = {tone_length_q, 15'd0} - DIV_D'(tone_length_q);
		quo_ext = {1'b0, div_quo[9:0]};
	end

	assign div_go       = cmd.div1_go | cmd.div2_go;
	assign div_dividend = cmd.div1_go ? {tone_freq_q, 32'd0} : DIV_N'(m2_q);
	assign div_divisor  = cmd.div1_go ? DIV_D'(rate_q) : den;

	dnsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_pct_q   <= VOLUME_RESET;
			rate_q      <= RATE_RESET;
			mono_q      <= 1'b0;
			tone_kind_q <= '0;
			tone_left_q <= '0;
			mix_q       <= 1'b0;
			for (int k = 0; k < KINDS; k++)
				pend_q[k] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VOLUME: vol_pct_q <= cfg_data[6:0];
					CFG_RATE:   rate_q    <= cfg_data[17:0];
					CFG_MONO:   mono_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.ev_take && in_data.event_kind < 3'(KINDS)) begin
				if (pend_q[in_data.event_kind] < PENDING_LIMIT)
					pend_q[in_data.event_kind] <= pend_q[in_data.event_kind] + 1'b1;
			end
			if (cmd.frame_take)
				mix_q <= 1'b0;
			if (cmd.pick) begin
				if (pick_hit) begin
					pend_q[pick_k] <= pend_q[pick_k] - 1'b1;
					tone_kind_q    <= pick_k + 3'd1;
					tone_left_q    <= spec.length;
				end else begin
					tone_kind_q <= '0;
					tone_left_q <= '0;
				end
			end
			if (cmd.tone_upd) begin
				tone_left_q <= tone_left_q - 1'b1;
				if (tone_left_q == 12'd1)
					tone_kind_q <= '0;
				mix_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_take) begin
			left_q  <= in_data.left_in;
			right_q <= in_data.right_in;
		end
		if (cmd.pick && pick_hit) begin
			tone_length_q <= spec.length;
			tone_freq_q   <= spec.freq;
			tone_vol_q    <= spec.vol;
			tone_phase_q  <= '0;
		end
		if (cmd.vol_mul)
			vprod_q <= 17'(tone_vol_q) * 17'(pct_c);
		if (cmd.vol_rec)
			vrec_q <= 35'(vprod_q) * 35'(VOL_RECIP);
		if (cmd.vol_set)
			tone_vol_q <= vrec_q[VOL_SHIFT+9:VOL_SHIFT];
		if (cmd.phase_upd)
			tone_phase_q <= tone_phase_q + div_quo[31:0];
		if (cmd.amp_mul1) begin
			m1_q  <= 25'(tri_mag) * 25'(tone_vol_q);
			neg_q <= tri_neg;
		end
		if (cmd.amp_mul2)
			m2_q <= 37'(m1_q) * 37'(tone_left_q);
		if (cmd.tone_upd)
			value_q <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
		if (cmd.out_load) begin
			if (mix_q) begin
				out_q.left_out  <= sat16(17'(left_q) + 17'(value_q));
				out_q.right_out <= mono_q ? right_q : sat16(17'(right_q) + 17'(value_q));
			end else begin
				out_q.left_out  <= left_q;
				out_q.right_out <= right_q;
			end
		end
	end

	assign stat.rate_zero = rate_q == '0;
	assign stat.tone_busy = tone_kind_q != '0;
	assign stat.pend_any  = pick_hit;
	assign stat.div_done  = div_done;
	assign out_data       = out_q;

endmodule
`default_nettype wire

### hw/rtl/dnsm_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
`default_nettype none
module dnsm_ctrl
	import dnsm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_op,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd,
	output logic          in_stall,
	output logic          out_valid
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_EVENT) begin
						cmd.ev_take = 1'b1;
					end else begin
						cmd.frame_take = 1'b1;
						if (stat.rate_zero)
							state_nx = ST_OUT;
						else if (stat.tone_busy)
							state_nx = ST_DIV1_GO;
						else
							state_nx = ST_PICK;
					end
				end
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_nx = stat.pend_any ? ST_VMUL : ST_OUT;
			end
			ST_VMUL: begin
				cmd.vol_mul = 1'b1;
				state_nx    = ST_VREC;
			end
			ST_VREC: begin
				cmd.vol_rec = 1'b1;
				state_nx    = ST_VSET;
			end
			ST_VSET: begin
				cmd.vol_set = 1'b1;
				state_nx    = ST_DIV1_GO;
			end
			ST_DIV1_GO: begin
				cmd.div1_go = 1'b1;
				state_nx    = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				if (stat.div_done) begin
					cmd.phase_upd = 1'b1;
					state_nx      = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.amp_mul1 = 1'b1;
				state_nx     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.amp_mul2 = 1'b1;
				state_nx     = ST_DIV2_GO;
			end
			ST_DIV2_GO: begin
				cmd.div2_go = 1'b1;
				state_nx    = ST_DIV2_WAIT;
			end
			ST_DIV2_WAIT: begin
				if (stat.div_done) begin
					cmd.tone_upd = 1'b1;
					state_nx     = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/disk_noise_synth_mixer.sv
// Top level of the disk noise synthesiser and mixer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | in        | in_valid / in_stall   | in_data  (op, event_kind, samples)
//  out     | out       | out_valid / out_stall | out_data (left_out, right_out)
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// An event transaction is taken without leaving the idle state and gives no result.
// A frame that starts or continues a tone makes two 42-step passes of the shared serial
// divider; a frame with nothing to play goes through ST_PICK to ST_OUT and a zero-rate
// frame goes straight to ST_OUT, each waiting in ST_OUT while a stalled result is held.
// in_stall is high from frame acceptance until its result enters the output register,
// which holds one result under out_stall. Reset clears counters, tone and out_valid.
`default_nettype none
module disk_noise_synth_mixer
	import dnsm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	dnsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	dnsm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

### hw/rtl/dnsm_checker.sv
// Port-level checker for the disk noise mixer, bound to the top level.
`default_nettype none
module dnsm_checker
	import dnsm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_event_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_EVENT && !out_valid |=> !out_valid)
		else $error("event transaction produced a result");

	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_FRAME |=> in_stall)
		else $error("input taken while a frame is in progress");

	a_event_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_EVENT |=> !in_stall)
		else $error("event transaction stalled the input");

endmodule

bind disk_noise_synth_mixer dnsm_checker u_dnsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

### dv/disk_noise_synth_mixer_tb.sv
// Self-checking testbench for the disk noise synthesiser and mixer.
`default_nettype none
module disk_noise_synth_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dnsm_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	disk_noise_synth_mixer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	in_item_t disk_traffic_q[$];
	out_item_t mixed_frame_q[$];
	int bad_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int quiet_cycles = 0;
	logic in_acc = 1'b0;

	// mirrored registers and tone state
	logic [6:0] vol_pct_m = VOLUME_RESET;
	logic [17:0] rate_m = RATE_RESET;
	logic mono_m = 1'b0;
	logic [CNT_W-1:0] pend_cnt [KINDS] = '{default: '0};
	logic [2:0] tone_kind = '0;
	logic [11:0] tone_left = '0;
	logic [11:0] tone_length = '0;
	logic [9:0] tone_freq = '0;
	logic [9:0] tone_vol = '0;
	logic [31:0] tone_phase = '0;
	int unsigned len_tab [KINDS] = '{1058, 2880, 720, 720, 480, 480};
	int unsigned freq_tab [KINDS] = '{820, 125, 420, 310, 210, 165};
	int unsigned vol_tab [KINDS] = '{950, 500, 300, 340, 260, 280};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void synth_and_mix(in_item_t it);
		int l;
		int r;
		int fold;
		int wave;
		int value;
		int pct;
		longint num;
		longint den;
		logic [63:0] step;
		bit hit;
		bit picked;
		out_item_t e;
		l = it.left_in;
		r = it.right_in;
		value = 0;
		hit = 1'b0;
		picked = 1'b0;
		if (it.op == OP_EVENT) begin
			if (it.event_kind < KINDS && pend_cnt[it.event_kind] < PENDING_LIMIT)
				pend_cnt[it.event_kind] = pend_cnt[it.event_kind] + 1'b1;
			return;
		end
		if (rate_m != 0) begin
			if (tone_kind == 0 && tone_left == 0) begin
				pct = (vol_pct_m > PCT_MAX) ? PCT_MAX : vol_pct_m;
				for (int k = 0; k < KINDS; k++) begin
					if (!picked && pend_cnt[k] != 0) begin
						pend_cnt[k] = pend_cnt[k] - 1'b1;
						tone_kind = 3'(k + 1);
						tone_length = 12'(len_tab[k]);
						tone_freq = 10'(freq_tab[k]);
						tone_vol = 10'(vol_tab[k] * pct / PCT_MAX);
						tone_left = tone_length;
						tone_phase = '0;
						picked = 1'b1;
					end
				end
				if (!picked) begin
					tone_kind = '0;
					tone_left = '0;
				end
			end
			if (tone_kind != 0 && tone_length != 0) begin
				step = (64'(tone_freq) << 32) / 64'(rate_m);
				tone_phase = tone_phase + step[31:0];
				fold = tone_phase[31:16];
				if (fold > 32767)
					fold = 65535 - fold;
				wave = fold * 2 - 32767;
				num = longint'(wave) * longint'(tone_vol) * longint'(tone_left);
				den = longint'(32767) * longint'(tone_length);
				value = int'(num / den);
				if (tone_left != 0)
					tone_left = tone_left - 1'b1;
				if (tone_left == 0)
					tone_kind = '0;
				hit = 1'b1;
			end else begin
				tone_kind = '0;
			end
		end
		if (hit) begin
			l = l + value;
			l = (l > 32767) ? 32767 : (l < -32768) ? -32768 : l;
			if (!mono_m) begin
				r = r + value;
				r = (r > 32767) ? 32767 : (r < -32768) ? -32768 : r;
			end
		end
		e.left_out = 16'(l);
		e.right_out = 16'(r);
		mixed_frame_q.push_back(e);
	endfunction

	function automatic void queue_event(logic [2:0] kind);
		in_item_t it;
		it.op = OP_EVENT;
		it.event_kind = kind;
		it.left_in = 16'($urandom);
		it.right_in = 16'($urandom);
		disk_traffic_q.push_back(it);
	endfunction

	function automatic void queue_frame(logic signed [15:0] l, logic signed [15:0] r);
		in_item_t it;
		it.op = OP_FRAME;
		it.event_kind = 3'($urandom_range(7));
		it.left_in = l;
		it.right_in = r;
		disk_traffic_q.push_back(it);
	endfunction

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'(32767 - int'($urandom_range(1000)));
			1: return 16'(-32768 + int'($urandom_range(1000)));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_VOLUME: vol_pct_m = val[6:0];
			CFG_RATE:   rate_m = val;
			CFG_MONO:   mono_m = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int n, int snd_pct, int rcv_pct);
		@(posedge clk);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85)
				queue_frame(rand_sample(), rand_sample());
			else
				queue_event(3'($urandom_range(7)));
		end
	endtask

	task automatic settle(int tail);
		while (disk_traffic_q.size() != 0 || in_valid || mixed_frame_q.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_acc) begin
			if (disk_traffic_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= disk_traffic_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		in_acc <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			synth_and_mix(in_data);
		if (out_valid && !out_stall) begin
			if (mixed_frame_q.size() == 0) begin
				if (bad_cnt < MAX_REPORTS)
					$display("unexpected frame: left %0d right %0d",
						out_data.left_out, out_data.right_out);
				bad_cnt++;
			end else begin
				want = mixed_frame_q.pop_front();
				if (out_data.left_out !== want.left_out ||
						out_data.right_out !== want.right_out) begin
					if (bad_cnt < MAX_REPORTS)
						$display("mismatch: expected %0d/%0d got %0d/%0d",
							want.left_out, want.right_out,
							out_data.left_out, out_data.right_out);
					bad_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("** disk_noise_synth_mixer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		send_idle_pct = 29;
		recv_idle_pct = 73;
		queue_frame(16'sd32767, -16'sd32768);
		queue_frame(-16'sd32768, 16'sd32767);
		queue_event(3'd6);
		queue_event(3'd7);
		queue_frame(16'h5555, 16'haaaa);
		repeat (9) queue_event(3'd5);
		queue_event(3'd4);
		queue_frame(16'sd32767, -16'sd32768);
		queue_frame(-16'sd32768, 16'sd32767);
		queue_event(3'd0);
		queue_event(3'd1);
		queue_event(3'd2);
		queue_event(3'd3);
		queue_frame(16'sd0, 16'sd0);
		queue_frame(-16'sd1, 16'sd1);
		settle(16);

		write_reg(CFG_VOLUME, 18'd100);
		write_reg(CFG_RATE, 18'd44100);
		write_reg(CFG_MONO, 18'd0);
		run_phase(150, 29, 73);
		settle(16);

		write_reg(CFG_VOLUME, 18'd127);
		write_reg(CFG_RATE, 18'd1);
		run_phase(120, 29, 73);
		settle(16);

		write_reg(CFG_VOLUME, 18'd0);
		write_reg(CFG_RATE, 18'd262143);
		write_reg(CFG_MONO, 18'd1);
		run_phase(150, 73, 29);
		settle(16);

		write_reg(CFG_VOLUME, 18'd50);
		write_reg(CFG_RATE, 18'd0);
		run_phase(50, 73, 29);
		settle(16);

		write_reg(CFG_VOLUME, 18'd100);
		write_reg(CFG_RATE, 18'd8000);
		write_reg(CFG_MONO, 18'd0);
		hold_req = 1'b1;
		run_phase(150, 0, 0);
		settle(16);

		write_reg(CFG_VOLUME, 18'd73);
		write_reg(CFG_RATE, 18'd200000);
		write_reg(CFG_MONO, 18'd1);
		run_phase(150, 0, 0);
		settle(200);

		bad_cnt = bad_cnt + mixed_frame_q.size();
		if (bad_cnt == 0)
			$display("** disk_noise_synth_mixer: PASSED **");
		else
			$display("** disk_noise_synth_mixer: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
hw/rtl/dnsm_pkg.sv
hw/rtl/dnsm_div.sv
hw/rtl/dnsm_datapath.sv
hw/rtl/dnsm_ctrl.sv
hw/rtl/disk_noise_synth_mixer.sv
hw/rtl/dnsm_checker.sv
dv/disk_noise_synth_mixer_tb.sv
